// File: design/variable_window_moving_average_defines.svh
// Assertion macros for the variable-window moving average.
// Included by the top level only; needs clk_i and rst_ni in scope.
`ifndef VARIABLE_WINDOW_MOVING_AVERAGE_DEFINES_SVH
`define VARIABLE_WINDOW_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VWMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vwma: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define VWMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vwma: assertion failed");

`endif

// File: design/vwma_pkg.sv
// Shared constants and types for the variable-window moving average.
// No dependencies; imported by every module of the block.
package vwma_pkg;

  localparam int HISTORY_DEPTH = 20;
  localparam int SAMPLE_BITS   = 12;

  // window register
  localparam int              WIN_W     = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd15;

  // derived widths
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
  localparam int MAG_W  = SUM_W;
  localparam int STEP_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

endpackage

// File: design/variable_window_moving_average.sv
// Variable-window moving average: top level with sequencer and output register.
// Depends on vwma_pkg, vwma_history, vwma_divider and the defines header.
//
// Each sample request pushes a signed 12-bit sample into a 20-deep history
// (oldest entry dropped) and returns one average: the sum of the newest N
// samples divided by N, truncated toward zero. N comes from the window
// register written over the cfg port (reset 15); 0 acts as 1 and values
// above 20 act as 20. The history is zero after reset, with no clearing
// pass, so early averages include those zeros. A sample goes through the
// accumulation of N entries through the single history read port, then
// the bit-serial divider, plus the sequencing steps (divider start, done
// flag, output load). s_axis_tready is high only while the sequencer is
// idle, so the next sample is taken only once the previous one is through.
// A finished result waits in the output register, so a new sample is taken
// while the previous average is still unclaimed; only when that register
// is still full at the output load step does the sequencer hold there until
// m_axis_tready frees it.
`include "variable_window_moving_average_defines.svh"

module variable_window_moving_average
  import vwma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // sample input; tdata[11:0] sample, tdata[15:12] zero
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,
  // average output; tdata[11:0] average, tdata[15:12] zero
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  // window length register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIN_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [WIN_W-1:0]       win_q;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [CNT_W-1:0]       eff_win;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   out_valid_q;

  logic                   in_accept;
  logic                   sum_last;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] hist_rd;
  logic [SUM_W-1:0]       hist_ext;
  logic                   sum_neg;
  logic [MAG_W-1:0]       sum_mag;
  div_req_t               div_req;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_quo;

  // Window register: always ready; the window is latched per request, so a
  // write during a request only affects later ones.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_valid_i) begin
      win_q <= cfg_data_i;
    end
  end

  // Clamp the window to 1..HISTORY_DEPTH.
  always_comb begin
    if (win_q == '0) begin
      eff_win = CNT_W'(1);
    end else if (int'(win_q) > HISTORY_DEPTH) begin
      eff_win = CNT_W'(HISTORY_DEPTH);
    end else begin
      eff_win = CNT_W'(win_q);
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign sum_last  = (CNT_W'(idx_q) == (n_q - 1'b1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_SUM;
      end
      S_SUM: begin
        if (sum_last) state_d = S_DIV_START;
      end
      S_DIV_START: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  assign sum_neg = sum_q[SUM_W-1];
  assign sum_mag = sum_neg ? (~sum_q + 1'b1) : sum_q;

  always_comb begin
    s_axis_tready = 1'b0;
    div_req       = '0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_DIV_START: begin
        div_req.start = 1'b1;
        div_req.neg   = sum_neg;
      end
      S_OUT: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Accumulator: one history entry per cycle, newest first.
  assign hist_ext = {{(SUM_W-SAMPLE_BITS){hist_rd[SAMPLE_BITS-1]}}, hist_rd};

  always_comb begin
    n_d   = n_q;
    idx_d = idx_q;
    sum_d = sum_q;
    if (in_accept) begin
      n_d   = eff_win;
      idx_d = '0;
      sum_d = '0;
    end else if (state_q == S_SUM) begin
      sum_d = sum_q + hist_ext;
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    idx_q <= idx_d;
    sum_q <= sum_d;
    if (out_load) begin
      out_q <= div_quo;
    end
  end

  vwma_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_accept),
    .sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .rd_idx_i  (idx_q),
    .rd_data_o (hist_rd)
  );

  vwma_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (sum_mag),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16-SAMPLE_BITS){1'b0}}, out_q};

  // A request starts a fresh accumulation from the newest entry.
  `VWMA_ASSERT_NXT(a_accept_starts_sum, in_accept, (state_q == S_SUM) && (idx_q == '0) && (sum_q == '0))
  // The read index stays inside the latched window while summing.
  `VWMA_ASSERT_IMP(a_idx_in_window, state_q == S_SUM, CNT_W'(idx_q) < n_q)
  // The latched window is clamped to 1..HISTORY_DEPTH while busy.
  `VWMA_ASSERT_IMP(a_window_clamped, state_q != S_IDLE, (n_q != '0) && (int'(n_q) <= HISTORY_DEPTH))
  // The divider only finishes while the sequencer waits for it.
  `VWMA_ASSERT_IMP(a_done_when_waiting, div_done, state_q == S_DIV_WAIT)

endmodule

// File: design/vwma_history.sv
// Sample history: shift line of HISTORY_DEPTH signed samples, entry 0 newest.
// Depends on vwma_pkg.
module vwma_history
  import vwma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [IDX_W-1:0]       rd_idx_i,
  output logic [SAMPLE_BITS-1:0] rd_data_o
);

  logic [SAMPLE_BITS-1:0] hist_q [HISTORY_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (push_i) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // index never exceeds the window, which is clamped to the depth
  assign rd_data_o = hist_q[rd_idx_i];

endmodule

// File: design/vwma_divider.sv
// Serial restoring divider: one quotient bit per cycle, magnitude in, sign out.
// Depends on vwma_pkg.
module vwma_divider
  import vwma_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  div_req_t               req_i,
  input  logic [MAG_W-1:0]       dividend_i,
  input  logic [CNT_W-1:0]       divisor_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  quo_q, quo_d;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;
  logic [SAMPLE_BITS-1:0] q_low;

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.neg;
      step_d = STEP_W'(MAG_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // magnitude is at most 2^(SAMPLE_BITS-1), so the low bits carry it whole
  assign q_low      = quo_q[SAMPLE_BITS-1:0];
  assign quotient_o = neg_q ? (~q_low + 1'b1) : q_low;
  assign done_o     = done_q;

endmodule

// File: verif/vwma_average_checker.sv
// Checker for the variable-window moving average: watches the sample, average
// and window channels, predicts each average and compares. Needs vwma_pkg.
`timescale 1ns / 1ps

module vwma_average_checker
  import vwma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sample_valid_i,
  input  logic             sample_ready_i,
  input  logic [15:0]      sample_data_i,
  input  logic             average_valid_i,
  input  logic             average_ready_i,
  input  logic [15:0]      average_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [WIN_W-1:0] cfg_data_i,
  output int               mismatch_count_o,
  output int               averages_due_o
);

  localparam int REPORT_LIMIT = 10;
  localparam int PAD_W        = 16 - SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] recent_samples [HISTORY_DEPTH];
  logic [WIN_W-1:0]              window_len;
  logic [15:0]                   averages_due [$];
  logic [15:0]                   want_avg;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) recent_samples[i] = '0;
    window_len       = WIN_RESET;
    mismatch_count_o = 0;
    averages_due_o   = 0;
  end

  // entry 0 newest; zero window acts as one, over-long saturates at the depth
  function automatic logic [SAMPLE_BITS-1:0] shift_in_and_average(
    input logic signed [SAMPLE_BITS-1:0] sample
  );
    int n;
    int total;
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) recent_samples[i] = recent_samples[i-1];
    recent_samples[0] = sample;
    n = window_len;
    if (n == 0) n = 1;
    if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
    total = 0;
    for (int i = 0; i < n; i++) total += recent_samples[i];
    return SAMPLE_BITS'(total / n);  // int division truncates toward zero
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) recent_samples[i] = '0;
      window_len = WIN_RESET;
      averages_due.delete();
    end else begin
      if (average_valid_i && average_ready_i) begin
        if (averages_due.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: unexpected average %0d", $realtime,
                     $signed(average_data_i[SAMPLE_BITS-1:0]));
          mismatch_count_o++;
        end else begin
          want_avg = averages_due.pop_front();
          if (average_data_i !== want_avg) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: average mismatch, expected %0d (0x%h) got %0d (0x%h)",
                       $realtime, $signed(want_avg[SAMPLE_BITS-1:0]), want_avg,
                       $signed(average_data_i[SAMPLE_BITS-1:0]), average_data_i);
            mismatch_count_o++;
          end
        end
      end
      if (sample_valid_i && sample_ready_i)
        averages_due.push_back({{PAD_W{1'b0}},
                                shift_in_and_average(sample_data_i[SAMPLE_BITS-1:0])});
      if (cfg_valid_i && cfg_ready_i) window_len = cfg_data_i;
    end
    averages_due_o = averages_due.size();
  end

endmodule

// File: verif/variable_window_moving_average_tb.sv
// Testbench top for the variable-window moving average: clock, reset, stimulus
// and verdict. Needs vwma_pkg, the block and vwma_average_checker.
`timescale 1ns / 1ps

module variable_window_moving_average_tb
  import vwma_pkg::*;
();

  localparam int TOTAL_ITEMS    = 1550;
  localparam int QUIET_TAIL     = 200;   // last requests run with no idling
  localparam int DRAIN_CYCLES   = 60;    // longest latency plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request accepted
  localparam int PAD_W          = 16 - SAMPLE_BITS;

  localparam logic [SAMPLE_BITS-1:0] S_MAX  = 12'h7FF;  // +2047
  localparam logic [SAMPLE_BITS-1:0] S_MIN  = 12'h800;  // -2048
  localparam logic [SAMPLE_BITS-1:0] S_MIN1 = 12'h801;  // -2047
  localparam logic [SAMPLE_BITS-1:0] S_NEG1 = 12'hFFF;  // -1
  localparam logic [SAMPLE_BITS-1:0] S_ZERO = 12'h000;
  localparam logic [SAMPLE_BITS-1:0] S_ONE  = 12'h001;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             s_tvalid  = 1'b0;
  logic [15:0]      s_tdata   = '0;
  logic             m_tready  = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [WIN_W-1:0] cfg_data  = '0;

  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic [15:0]      m_axis_tdata;
  logic             cfg_ready;

  int mismatches;
  int averages_due;

  // idling knobs, odds out of 8 (gaps per request, stalls per sink decision); zero gives a calm stretch
  bit idle_en    = 1'b1;
  int gap_odds   = 2;
  int stall_odds = 2;
  int items_sent = 0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  variable_window_moving_average u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  vwma_average_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (s_tvalid),
    .sample_ready_i   (s_axis_tready),
    .sample_data_i    (s_tdata),
    .average_valid_i  (m_axis_tvalid),
    .average_ready_i  (m_tready),
    .average_data_i   (m_axis_tdata),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .averages_due_o   (averages_due)
  );

  // Average sink: random back-pressure in bursts.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_en && stall_odds != 0 && $urandom_range(1, 8) <= stall_odds) begin
      hold_left = $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("variable_window_moving_average_tb failed");
      $finish;
    end
  end

  // One sample request, with an optional idle burst in front. tvalid stays
  // high afterwards so back-to-back requests never drop it within a step.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    int gap;
    if (idle_en && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, value};
    do @(posedge clk_i); while (!(s_tvalid && s_axis_tready));
    items_sent++;
    if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) idle_en = 1'b0;
  endtask

  // Window writes only with the block idle: first let the last sample's
  // prediction be queued, then wait until every average has been taken.
  task automatic write_window(input logic [WIN_W-1:0] len);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (averages_due == 0);
    repeat (2) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                     phase_len;
    int                     style;
    int                     run_len;
    int                     small_val;
    logic [WIN_W-1:0]       len;
    logic [SAMPLE_BITS-1:0] run_val;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // reset window of 15, history still zero
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    // zero window acts as one
    write_window(5'd0);
    send_sample(S_MIN);
    send_sample(S_MAX);
    // window of two: negative halves must truncate toward zero
    write_window(5'd2);
    send_sample(S_NEG1);
    send_sample(S_ZERO);
    send_sample(S_ONE);
    send_sample(S_MIN);
    send_sample(S_MIN1);
    // largest code saturates at the full depth
    write_window(5'd31);
    send_sample(S_MIN);
    send_sample(S_MAX);
    write_window(5'd20);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MIN);
    // just above the depth
    write_window(5'd21);
    send_sample(S_MAX);
    send_sample(S_MAX);
    // sum of -1 over three rounds to zero
    write_window(5'd3);
    send_sample(S_NEG1);
    send_sample(S_NEG1);
    send_sample(S_ONE);

    // --- random part, in phases of one window setting each ---
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 6))
        0: len = 5'd0;
        1: len = 5'd1;
        2: len = 5'd20;
        3: len = 5'd31;
        4: len = WIN_W'($urandom_range(21, 31));
        default: len = WIN_W'($urandom_range(0, 31));
      endcase
      write_window(len);
      gap_odds   = $urandom_range(0, 3);
      stall_odds = $urandom_range(0, 3);
      phase_len  = $urandom_range(30, 110);
      while (phase_len > 0 && items_sent < TOTAL_ITEMS) begin
        style = $urandom_range(0, 9);
        if (style < 2) begin
          // run of one extreme, at times long enough to fill the whole history
          run_val = $urandom_range(0, 1) ? S_MAX : S_MIN;
          run_len = $urandom_range(5, 25);
          while (run_len > 0 && items_sent < TOTAL_ITEMS) begin
            send_sample(run_val);
            run_len--;
            phase_len--;
          end
        end else if (style < 4) begin
          // values near zero, where truncation direction shows
          small_val = int'($urandom_range(0, 6)) - 3;
          send_sample(small_val[SAMPLE_BITS-1:0]);
          phase_len--;
        end else begin
          send_sample(SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
          phase_len--;
        end
      end
    end

    // --- drain and verdict ---
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (averages_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && averages_due == 0) begin
      $display("variable_window_moving_average_tb passed");
    end else begin
      $display("variable_window_moving_average_tb failed");
    end
    $finish;
  end

endmodule
